FILE: sv/affine_box_transform_core_macros.svh
// Assertion macros shared by the affine box transform checker.
`ifndef AFFINE_BOX_TRANSFORM_CORE_MACROS_SVH
`define AFFINE_BOX_TRANSFORM_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ABT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define ABT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: sv/abt_pkg.sv
// Package with shared constants and types of the affine box transform.
package abt_pkg;
    localparam int COEF_FRAC = 12;
    localparam int NUM_CFG   = 6;
    localparam int PIPE_LAT  = 4 + 13;
    typedef enum logic [2:0] {
        CFG_ROW_X   = 3'd0,
        CFG_ROW_Y   = 3'd1,
        CFG_ROW_Z   = 3'd2,
        CFG_SHIFT_X = 3'd3,
        CFG_SHIFT_Y = 3'd4,
        CFG_SHIFT_Z = 3'd5
    } t_cfg_idx;
endpackage

FILE: sv/abt_sqrt_pipe.sv
// Pipelined rounded integer square root, two result bits per stage.
module abt_sqrt_pipe
    import abt_pkg::*;
#(
    parameter int IN_W = 50
) (
    input  logic                i_clk,
    input  logic [IN_W-1:0]     i_val,
    output logic [IN_W/2:0]     o_root
);
    localparam int NS = (IN_W + 3) / 4;
    localparam int W  = 4 * NS;
    localparam int RW = 2 * NS;

    logic [W-1:0]  r_rem  [1:NS];
    logic [RW:0]   r_root [1:NS];
    logic [W-1:0]  r_n    [1:NS];

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_st
            logic [W-1:0] s_rem;
            logic [RW:0]  s_root;
            logic [W-1:0] s_n;
            logic [W-1:0] n_rem;
            logic [RW:0]  n_root;
            logic [W-1:0] n_n;
            logic [W+1:0] rem2, trial;
            logic         b;
            if (g == 0) begin : g_first
                assign s_rem  = '0;
                assign s_root = '0;
                assign s_n    = W'(i_val);
            end else begin : g_next
                assign s_rem  = r_rem[g];
                assign s_root = r_root[g];
                assign s_n    = r_n[g];
            end
            always_comb begin
                n_rem  = s_rem;
                n_root = s_root;
                n_n    = s_n;
                for (int k = 0; k < 2; k++) begin
                    rem2  = {n_rem, n_n[W-1 -: 2]};
                    n_n   = {n_n[W-3:0], 2'b00};
                    trial = {n_root, 2'b01};
                    b     = (rem2 >= trial);
                    n_rem = b ? W'(rem2 - trial) : W'(rem2);
                    n_root = {n_root[RW-1:0], b};
                end
            end
            always_ff @(posedge i_clk) begin
                r_rem[g+1]  <= n_rem;
                r_root[g+1] <= n_root;
                r_n[g+1]    <= n_n;
            end
        end
    endgenerate

    // Round to nearest: remainder above the floor root bumps it.
    always_comb begin
        o_root = (IN_W/2+1)'(r_root[NS]) +
                 (IN_W/2+1)'((W+1)'(r_rem[NS]) > (W+1)'(r_root[NS]));
    end
endmodule

FILE: sv/affine_box_transform_core.sv
// Top level of the pipelined affine transform of axis-aligned boxes.
//
//  channel   signals                          direction  notes
//  command   i_start/o_busy + box fields      in         accepted when start & !busy
//  result    o_result_strobe + result fields  out        one cycle, cannot be held off
//  config    i_cfg_valid/o_cfg_ready/idx/data in         always ready
//
// One request enters per cycle; o_busy is held low. A request taken at a rising
// edge has its result on the ports after four arithmetic stages (multiply,
// accumulate and round, corners and saturation, sum of squares) followed by the
// square-root stages of the radius. Reset (synchronous, active low) clears the
// valid bits and loads the identity matrix and zero shift. The receiver cannot
// stall, so there is no stall path.
module affine_box_transform_core
    import abt_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [COORD_WIDTH-1:0]   i_center_x,
    input  logic [COORD_WIDTH-1:0]   i_center_y,
    input  logic [COORD_WIDTH-1:0]   i_center_z,
    input  logic [COORD_WIDTH-2:0]   i_half_x,
    input  logic [COORD_WIDTH-2:0]   i_half_y,
    input  logic [COORD_WIDTH-2:0]   i_half_z,
    input  logic                     i_box_valid,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [2:0]               i_cfg_index,
    input  logic [3*COEF_WIDTH-1:0]  i_cfg_data,
    output logic                     o_result_strobe,
    output logic [COORD_WIDTH-1:0]   o_min_x,
    output logic [COORD_WIDTH-1:0]   o_min_y,
    output logic [COORD_WIDTH-1:0]   o_min_z,
    output logic [COORD_WIDTH-1:0]   o_max_x,
    output logic [COORD_WIDTH-1:0]   o_max_y,
    output logic [COORD_WIDTH-1:0]   o_max_z,
    output logic [COORD_WIDTH-1:0]   o_new_center_x,
    output logic [COORD_WIDTH-1:0]   o_new_center_y,
    output logic [COORD_WIDTH-1:0]   o_new_center_z,
    output logic [COORD_WIDTH-1:0]   o_radius,
    output logic                     o_result_valid
);
    localparam int CW  = COORD_WIDTH;
    localparam int KW  = COEF_WIDTH;
    localparam int PW  = CW + KW;        // product width
    localparam int AW  = PW + 3;         // accumulator width
    localparam int HW  = AW - COEF_FRAC; // rounded value width (signed)
    localparam int SQW = 2 * CW + 2;     // sum of three squares, no overflow
    localparam int NSQ = (SQW + 3) / 4;
    localparam int LAT = 4 + NSQ;

    // Configuration registers.
    logic [3*KW-1:0] r_row [0:2];
    logic [CW-1:0]   r_shift [0:2];

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_row[i]   <= (3*KW)'(1) << (COEF_FRAC + i*KW);
                r_shift[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROW_X:   r_row[0]   <= i_cfg_data;
                CFG_ROW_Y:   r_row[1]   <= i_cfg_data;
                CFG_ROW_Z:   r_row[2]   <= i_cfg_data;
                CFG_SHIFT_X: r_shift[0] <= i_cfg_data[CW-1:0];
                CFG_SHIFT_Y: r_shift[1] <= i_cfg_data[CW-1:0];
                CFG_SHIFT_Z: r_shift[2] <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0]   c_in [0:2];
    logic [CW-2:0]   h_in [0:2];
    assign c_in = '{i_center_x, i_center_y, i_center_z};
    assign h_in = '{i_half_x, i_half_y, i_half_z};

    logic r_v [0:LAT-1];
    logic n_v0;
    assign n_v0 = i_start & i_box_valid;

    // Stage 1: nine signed products of center and nine unsigned extent products.
    logic signed [PW-1:0] r_cp [0:2][0:2];
    logic        [PW-1:0] r_ep [0:2][0:2];
    logic signed [CW-1:0] r_t1 [0:2];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_t1[i] <= r_shift[i];
            for (int j = 0; j < 3; j++) begin
                logic signed [KW-1:0] m;
                logic        [KW-1:0] am;
                m  = r_row[i][j*KW +: KW];
                am = m[KW-1] ? KW'(-m) : m;
                r_cp[i][j] <= PW'(m) * PW'($signed(c_in[j]));
                r_ep[i][j] <= PW'(am) * PW'(h_in[j]);
            end
        end
    end

    // Stage 2: accumulate in Q.12 and round to Q.0 integers (ties toward plus infinity).
    logic signed [HW-1:0] r_ctr [0:2];
    logic signed [HW-1:0] r_ext [0:2];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            logic signed [AW-1:0] a;
            logic        [AW-1:0] e;
            a = (AW'(r_t1[i]) <<< COEF_FRAC) + AW'(r_cp[i][0]) + AW'(r_cp[i][1])
                + AW'(r_cp[i][2]) + AW'(1 << (COEF_FRAC-1));
            e = AW'(r_ep[i][0]) + AW'(r_ep[i][1]) + AW'(r_ep[i][2])
                + AW'(1 << (COEF_FRAC-1));
            r_ctr[i] <= HW'(a >>> COEF_FRAC);
            r_ext[i] <= HW'(e >> COEF_FRAC);
        end
    end

    // Stage 3: corners and saturation; half-extents truncated for the squares, overflow flagged.
    function automatic logic [CW-1:0] sat(input logic signed [HW:0] v);
        logic signed [HW:0] hi, lo;
        hi = (HW+1)'((64'(1) << (CW-1)) - 1);
        lo = -hi - 1;
        if (v > hi)      sat = hi[CW-1:0];
        else if (v < lo) sat = lo[CW-1:0];
        else             sat = v[CW-1:0];
    endfunction

    logic [CW-1:0] r_mn [0:2], r_mx [0:2], r_nc [0:2];
    logic [CW-1:0] r_e3 [0:2];
    logic          r_ovf3;
    always_ff @(posedge i_clk) begin
        logic o;
        o = 1'b0;
        for (int i = 0; i < 3; i++) begin
            r_mn[i] <= sat((HW+1)'(r_ctr[i]) - (HW+1)'(r_ext[i]));
            r_mx[i] <= sat((HW+1)'(r_ctr[i]) + (HW+1)'(r_ext[i]));
            r_nc[i] <= sat((HW+1)'(r_ctr[i]));
            if (r_ext[i] > (HW)'((64'(1) << CW) - 1)) o = 1'b1;
            r_e3[i] <= r_ext[i][CW-1:0];
        end
        r_ovf3 <= o;
    end

    // Stage 4: squares summed.
    logic [SQW-1:0] r_sum;
    always_ff @(posedge i_clk) begin
        r_sum <= SQW'(r_e3[0]) * SQW'(r_e3[0]) + SQW'(r_e3[1]) * SQW'(r_e3[1])
                 + SQW'(r_e3[2]) * SQW'(r_e3[2]);
    end

    logic [SQW/2:0] root;
    abt_sqrt_pipe #(.IN_W(SQW)) u_sqrt (
        .i_clk (i_clk),
        .i_val (r_sum),
        .o_root(root)
    );

    // Delay lines that align the other fields with the root. The first tap is
    // loaded alongside the sum of squares, so the last one lines up with the
    // final square-root stage.
    logic [CW-1:0] r_dmn [0:NSQ][0:2], r_dmx [0:NSQ][0:2], r_dnc [0:NSQ][0:2];
    logic          r_dov [0:NSQ];
    always_ff @(posedge i_clk) begin
        r_dmn[0] <= r_mn;
        r_dmx[0] <= r_mx;
        r_dnc[0] <= r_nc;
        r_dov[0] <= r_ovf3;
        for (int k = 0; k < NSQ; k++) begin
            r_dmn[k+1] <= r_dmn[k];
            r_dmx[k+1] <= r_dmx[k];
            r_dnc[k+1] <= r_dnc[k];
            r_dov[k+1] <= r_dov[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= n_v0;
            for (int k = 0; k < LAT-1; k++) r_v[k+1] <= r_v[k];
        end
    end
    logic r_s [0:LAT-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_s[k] <= 1'b0;
        end else begin
            r_s[0] <= i_start;
            for (int k = 0; k < LAT-1; k++) r_s[k+1] <= r_s[k];
        end
    end

    // Output: the root leaves the sqrt combinationally after its last stage.
    logic          vout;
    logic [CW-1:0] rad;
    assign vout = r_v[LAT-1];
    assign rad  = (r_dov[NSQ] || (root > (SQW/2+1)'((64'(1) << CW) - 1)))
                  ? {CW{1'b1}} : root[CW-1:0];

    assign o_result_strobe = r_s[LAT-1];
    assign o_result_valid  = vout;
    assign o_min_x        = vout ? r_dmn[NSQ][0] : '0;
    assign o_min_y        = vout ? r_dmn[NSQ][1] : '0;
    assign o_min_z        = vout ? r_dmn[NSQ][2] : '0;
    assign o_max_x        = vout ? r_dmx[NSQ][0] : '0;
    assign o_max_y        = vout ? r_dmx[NSQ][1] : '0;
    assign o_max_z        = vout ? r_dmx[NSQ][2] : '0;
    assign o_new_center_x = vout ? r_dnc[NSQ][0] : '0;
    assign o_new_center_y = vout ? r_dnc[NSQ][1] : '0;
    assign o_new_center_z = vout ? r_dnc[NSQ][2] : '0;
    assign o_radius       = vout ? rad : '0;
endmodule

FILE: sv/abt_checker.sv
// Port-level checker for the affine box transform core, with its bind.
`include "affine_box_transform_core_macros.svh"
module abt_checker #(
    parameter int CW = 24
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_busy,
    input logic          o_result_strobe,
    input logic          o_result_valid,
    input logic [CW-1:0] o_min_x,
    input logic [CW-1:0] o_max_x,
    input logic [CW-1:0] o_radius
);
    `ABT_ASSERT_IMP(a_never_busy, i_clk, i_rst_n, 1'b1, !o_busy)
    `ABT_ASSERT_IMP(a_valid_strobed, i_clk, i_rst_n, o_result_valid, o_result_strobe)
    `ABT_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n, !o_result_valid,
        o_min_x == '0 && o_max_x == '0 && o_radius == '0)
endmodule

bind affine_box_transform_core abt_checker #(.CW(COORD_WIDTH)) u_abt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_busy(o_busy),
    .o_result_strobe(o_result_strobe), .o_result_valid(o_result_valid),
    .o_min_x(o_min_x), .o_max_x(o_max_x), .o_radius(o_radius)
);

FILE: verif/affine_box_transform_core_checker.sv
// Checker for the affine box transform: predicts each box result and compares it.
`timescale 1ns / 1ps
module affine_box_transform_core_checker
    import abt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [23:0] i_center_x,
    input  logic [23:0] i_center_y,
    input  logic [23:0] i_center_z,
    input  logic [22:0] i_half_x,
    input  logic [22:0] i_half_y,
    input  logic [22:0] i_half_z,
    input  logic        i_box_valid,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        i_result_strobe,
    input  logic [23:0] i_min_x,
    input  logic [23:0] i_min_y,
    input  logic [23:0] i_min_z,
    input  logic [23:0] i_max_x,
    input  logic [23:0] i_max_y,
    input  logic [23:0] i_max_z,
    input  logic [23:0] i_new_center_x,
    input  logic [23:0] i_new_center_y,
    input  logic [23:0] i_new_center_z,
    input  logic [23:0] i_radius,
    input  logic        i_result_valid,
    output int          o_mismatches,
    output int          o_pending
);
    localparam longint COORD_MAX = 64'sd8388607;
    localparam longint COORD_MIN = -64'sd8388608;
    localparam longint RAD_MAX   = 64'sd16777215;

    // Fields 0..2 min corner, 3..5 max corner, 6..8 center, 9 radius, 10 valid.
    typedef logic [10:0][23:0] box_res_t;

    logic [47:0] row_coefs [3];
    logic [23:0] shift_reg [3];
    box_res_t    boxes_due [$];
    string       field_name [11] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z",
                                     "new_center_x", "new_center_y", "new_center_z",
                                     "radius", "result_valid"};

    function automatic logic [23:0] clamp_coord(input longint v);
        longint r;
        r = (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
        return r[23:0];
    endfunction

    // Integer square root rounded to nearest.
    function automatic logic [63:0] sqrt_nearest(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (n > r) r = r + 1;
        return r;
    endfunction

    function automatic box_res_t transform_box(input logic [2:0][23:0] ctr_in,
                                               input logic [2:0][22:0] half_in,
                                               input logic valid);
        box_res_t    res;
        longint      acc, eacc, m, ctr, rad;
        longint      ext [3];
        logic [63:0] sq_sum;
        bit          ovf;
        res = '0;
        if (!valid) return res;
        sq_sum = 0;
        ovf = 0;
        for (int i = 0; i < 3; i++) begin
            acc  = longint'($signed(shift_reg[i])) * 4096;
            eacc = 0;
            for (int j = 0; j < 3; j++) begin
                m = longint'($signed(row_coefs[i][16*j +: 16]));
                acc  += m * longint'($signed(ctr_in[j]));
                eacc += ((m < 0) ? -m : m) * longint'(half_in[j]);
            end
            // Round half up, once, from the exact Q.12 sums.
            ctr    = (acc + 2048) >>> 12;
            ext[i] = (eacc + 2048) >>> 12;
            res[i]     = clamp_coord(ctr - ext[i]);
            res[3 + i] = clamp_coord(ctr + ext[i]);
            res[6 + i] = clamp_coord(ctr);
            if (ext[i] > RAD_MAX) ovf = 1;
            else sq_sum += 64'(ext[i] * ext[i]);
        end
        rad = ovf ? RAD_MAX : longint'(sqrt_nearest(sq_sum));
        if (rad > RAD_MAX) rad = RAD_MAX;
        res[9]  = rad[23:0];
        res[10] = 24'd1;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        o_mismatches++;
    endtask

    initial o_mismatches = 0;
    assign o_pending = boxes_due.size();

    always @(posedge i_clk) begin
        box_res_t got;
        box_res_t want;
        if (!i_rst_n) begin
            row_coefs[0] <= 48'h0000_0000_1000;
            row_coefs[1] <= 48'h0000_1000_0000;
            row_coefs[2] <= 48'h1000_0000_0000;
            for (int i = 0; i < 3; i++) shift_reg[i] <= '0;
        end else begin
            if (i_start && !i_busy)
                boxes_due.push_back(transform_box({i_center_z, i_center_y, i_center_x},
                                                  {i_half_z, i_half_y, i_half_x},
                                                  i_box_valid));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROW_X:   row_coefs[0] <= i_cfg_data;
                    CFG_ROW_Y:   row_coefs[1] <= i_cfg_data;
                    CFG_ROW_Z:   row_coefs[2] <= i_cfg_data;
                    CFG_SHIFT_X: shift_reg[0] <= i_cfg_data[23:0];
                    CFG_SHIFT_Y: shift_reg[1] <= i_cfg_data[23:0];
                    CFG_SHIFT_Z: shift_reg[2] <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (i_result_strobe) begin
                got = {24'(i_result_valid), i_radius, i_new_center_z, i_new_center_y,
                       i_new_center_x, i_max_z, i_max_y, i_max_x, i_min_z, i_min_y, i_min_x};
                if (boxes_due.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = boxes_due.pop_front();
                    for (int f = 0; f < 11; f++)
                        if (got[f] !== want[f])
                            report_mismatch($sformatf("%s got %h expected %h",
                                                      field_name[f], got[f], want[f]));
                end
            end
        end
    end
endmodule

FILE: verif/tb_affine_box_transform_core.sv
// Testbench top for the affine box transform core: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb_affine_box_transform_core;
    import abt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [23:0] i_center_x, i_center_y, i_center_z;
    logic [22:0] i_half_x, i_half_y, i_half_z;
    logic        i_box_valid;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [47:0] i_cfg_data;
    logic        o_result_strobe;
    logic [23:0] o_min_x, o_min_y, o_min_z, o_max_x, o_max_y, o_max_z;
    logic [23:0] o_new_center_x, o_new_center_y, o_new_center_z, o_radius;
    logic        o_result_valid;
    int          mismatches;
    int          pending;
    int          idle_pct;

    affine_box_transform_core dut (.*);

    // The checker sees both channels and the config port exactly as the block does.
    affine_box_transform_core_checker checker_i (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy),
        .i_center_x, .i_center_y, .i_center_z, .i_half_x, .i_half_y, .i_half_z,
        .i_box_valid, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_result_strobe(o_result_strobe), .i_min_x(o_min_x), .i_min_y(o_min_y),
        .i_min_z(o_min_z), .i_max_x(o_max_x), .i_max_y(o_max_y), .i_max_z(o_max_z),
        .i_new_center_x(o_new_center_x), .i_new_center_y(o_new_center_y),
        .i_new_center_z(o_new_center_z), .i_radius(o_radius),
        .i_result_valid(o_result_valid), .o_mismatches(mismatches), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Hard stop in case the block hangs: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("tb_affine_box_transform_core: done, errors");
        $finish;
    end

    // Every input is driven at the falling edge with blocking assignments, so the
    // block and the checker see settled values at the rising edge.
    task automatic send_box(input logic [23:0] cx, input logic [23:0] cy,
                            input logic [23:0] cz, input logic [22:0] hx,
                            input logic [22:0] hy, input logic [22:0] hz,
                            input logic valid);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_center_x = cx;
        i_center_y = cy;
        i_center_z = cz;
        i_half_x = hx;
        i_half_y = hy;
        i_half_z = hz;
        i_box_valid = valid;
        i_start = 1'b1;
        do begin
            // Busy only changes at rising edges, so its value in the low half of
            // the cycle decides whether the coming rising edge takes the request.
            taken = !o_busy;
            @(negedge i_clk);
        end while (!taken);
        i_start = 1'b0;
    endtask

    task automatic send_random_box();
        logic [23:0] c [3];
        logic [22:0] h [3];
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(3))
                0: c[k] = 24'($urandom);
                1: c[k] = 24'($signed($urandom_range(0, 8191)) - 4096);
                2: c[k] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                default: c[k] = 24'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
            endcase
            case ($urandom_range(3))
                0: h[k] = 23'($urandom);
                1: h[k] = 23'($urandom_range(0, 4096));
                2: h[k] = $urandom_range(0, 1) ? 23'h7FFFFF : 23'h0;
                default: h[k] = 23'($urandom_range(0, 500_000));
            endcase
        end
        send_box(c[0], c[1], c[2], h[0], h[1], h[2], $urandom_range(9) != 0);
    endtask

    // Let the pipeline drain completely before the configuration changes.
    task automatic drain();
        i_start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        bit taken;
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do begin
            taken = o_cfg_ready;
            @(negedge i_clk);
        end while (!taken);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_matrix(input logic [47:0] rx, input logic [47:0] ry,
                               input logic [47:0] rz, input logic [23:0] sx,
                               input logic [23:0] sy, input logic [23:0] sz);
        drain();
        write_reg(CFG_ROW_X, rx);
        write_reg(CFG_ROW_Y, ry);
        write_reg(CFG_ROW_Z, rz);
        write_reg(CFG_SHIFT_X, {24'h0, sx});
        write_reg(CFG_SHIFT_Y, {24'h0, sy});
        write_reg(CFG_SHIFT_Z, {24'h0, sz});
    endtask

    function automatic logic [15:0] random_coef();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 16'h2000)) - 16'sh1000);
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return $urandom_range(0, 1) ? 16'h1000 : 16'h0000;
        endcase
    endfunction

    task automatic random_matrix();
        load_matrix({random_coef(), random_coef(), random_coef()},
                    {random_coef(), random_coef(), random_coef()},
                    {random_coef(), random_coef(), random_coef()},
                    24'($urandom), 24'($urandom), 24'($urandom));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_center_x = '0;
        i_center_y = '0;
        i_center_z = '0;
        i_half_x = '0;
        i_half_y = '0;
        i_half_z = '0;
        i_box_valid = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_pct = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Identity matrix straight out of reset: the coordinate extremes pass
        // through, and the corners saturate when the extents push past them.
        send_box(24'h7FFFFF, 24'h800000, 24'h000000, 23'h0, 23'h0, 23'h0, 1'b1);
        send_box(24'h7FFFFF, 24'h800000, 24'h000001, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 1'b1);
        send_box(24'h000100, 24'hFFFF00, 24'h000000, 23'h000100, 23'h000200, 23'h0, 1'b1);
        // An invalid box must zero the whole result even with busy fields.
        send_box(24'h123456, 24'hFEDCBA, 24'h7FFFFF, 23'h7FFFFF, 23'h2AAAAA, 23'h555555, 1'b0);

        // Largest negative coefficients with extreme shifts: centers and extents overflow
        // and the radius sum exceeds its range.
        load_matrix({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                    24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send_box(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 1'b1);
        send_box(24'h800000, 24'h800000, 24'h800000, 23'h0, 23'h0, 23'h0, 1'b1);
        send_box(24'h000001, 24'h000000, 24'hFFFFFF, 23'h000001, 23'h0, 23'h0, 1'b1);

        // Largest positive coefficients with the most negative shift.
        load_matrix({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                    24'h800000, 24'h800000, 24'h800000);
        send_box(24'h7FFFFF, 24'h800000, 24'h000000, 23'h7FFFFF, 23'h0, 23'h0, 1'b1);
        send_box(24'h000000, 24'h000000, 24'h000000, 23'h000010, 23'h000010, 23'h0, 1'b1);

        // Plus and minus one half: odd centers land exactly on a rounding tie,
        // which has to go toward plus infinity in both signs.
        load_matrix({16'h0, 16'h0, 16'h0800}, {16'h0, 16'hF800, 16'h0},
                    {16'h0800, 16'h0, 16'h0800}, 24'h0, 24'h0, 24'hFFFFFF);
        // Register indexes past the end are ignored by the block.
        write_reg(3'd6, 48'hFFFF_FFFF_FFFF);
        write_reg(3'd7, 48'h1234_5678_9ABC);
        send_box(24'h000001, 24'h000001, 24'h000001, 23'h000001, 23'h000001, 23'h000001, 1'b1);
        send_box(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFD, 23'h000003, 23'h000003, 23'h000005, 1'b1);
        send_box(24'h000003, 24'hFFFFFD, 24'h000000, 23'h000007, 23'h0, 23'h000001, 1'b1);

        // Random part in three rounds of sender idling, a new matrix every
        // fifty requests.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 27 : ((phase == 1) ? 55 : 0);
            for (int n = 0; n < 316; n++) begin
                if (n % 50 == 0) random_matrix();
                // Once per round the sender waits for the pipeline to empty
                // without touching the configuration.
                if (n == 25) begin
                    i_start = 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
                send_random_box();
            end
        end

        i_start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 5) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tb_affine_box_transform_core: done, clean");
        end else begin
            $display("tb_affine_box_transform_core: done, errors");
        end
        $finish;
    end
endmodule
